// ===== rtl/core/cffip_pkg.sv =====
// Shared types and constants for the CFF INDEX parser.
// Used by cffip_front, cffip_queue and cff_index_parser_core; no dependencies.
package cffip_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam int unsigned ValueW = 32;
  localparam int unsigned EntryW = 16;
  localparam int unsigned TotalW = 33;

  typedef enum logic [1:0] {
    KindOffset  = 2'd0,
    KindData    = 2'd1,
    KindEmpty   = 2'd2,
    KindBadSize = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [ValueW-1:0]  value;
    logic [EntryW-1:0]  entry_number;
    logic               is_last;
    logic [TotalW-1:0]  index_bytes;
  } result_t;

endpackage

// ===== rtl/core/cffip_front.sv =====
// Front end of the CFF INDEX parser: takes stream bytes and runs the header,
// offset and data phases, producing one result word per byte that has one.
// Depends on cffip_pkg.
module cffip_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          stream_byte_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output cffip_pkg::result_t  res_o
);

  localparam logic [2:0] PhCountHi = 3'd0;
  localparam logic [2:0] PhCountLo = 3'd1;
  localparam logic [2:0] PhOffSize = 3'd2;
  localparam logic [2:0] PhOffsets = 3'd3;
  localparam logic [2:0] PhData    = 3'd4;

  logic [2:0]  phase_q, phase_d;
  logic [15:0] entry_count_q, entry_count_d;
  logic [2:0]  offset_width_q, offset_width_d;
  logic [16:0] entries_done_q, entries_done_d;
  logic [1:0]  byte_in_offset_q, byte_in_offset_d;
  logic [31:0] offset_acc_q, offset_acc_d;
  logic [31:0] data_remaining_q, data_remaining_d;
  logic [33:0] bytes_consumed_q, bytes_consumed_d;

  logic        accept;
  logic        emit;
  logic [15:0] count_full;
  logic [31:0] acc_next;
  logic [31:0] offset_val;
  logic [2:0]  bio_next;
  logic [31:0] dr_next;

  assign in_ready_o  = res_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign res_valid_o = in_valid_i && emit;

  assign count_full = {entry_count_q[7:0], stream_byte_i};
  assign acc_next   = {offset_acc_q[23:0], stream_byte_i};
  assign offset_val = acc_next - 32'd1;
  assign bio_next   = {1'b0, byte_in_offset_q} + 3'd1;
  assign dr_next    = data_remaining_q - 32'd1;

  always_comb begin
    phase_d          = phase_q;
    entry_count_d    = entry_count_q;
    offset_width_d   = offset_width_q;
    entries_done_d   = entries_done_q;
    byte_in_offset_d = byte_in_offset_q;
    offset_acc_d     = offset_acc_q;
    data_remaining_d = data_remaining_q;
    emit             = 1'b0;
    res_o.kind         = cffip_pkg::KindOffset;
    res_o.value        = '0;
    res_o.entry_number = '0;
    res_o.is_last      = 1'b0;

    unique case (phase_q)
      PhCountLo: begin
        bytes_consumed_d = bytes_consumed_q + 34'd1;
        entry_count_d    = count_full;
        if (count_full == 16'd0) begin
          emit          = 1'b1;
          res_o.kind    = cffip_pkg::KindEmpty;
          res_o.is_last = 1'b1;
          phase_d       = PhCountHi;
        end else begin
          phase_d = PhOffSize;
        end
      end
      PhOffSize: begin
        bytes_consumed_d = bytes_consumed_q + 34'd1;
        if (stream_byte_i < 8'd1 || stream_byte_i > 8'd4) begin
          emit          = 1'b1;
          res_o.kind    = cffip_pkg::KindBadSize;
          res_o.value   = {24'd0, stream_byte_i};
          res_o.is_last = 1'b1;
          phase_d       = PhCountHi;
        end else begin
          offset_width_d   = stream_byte_i[2:0];
          entries_done_d   = '0;
          byte_in_offset_d = '0;
          offset_acc_d     = '0;
          phase_d          = PhOffsets;
        end
      end
      PhOffsets: begin
        bytes_consumed_d = bytes_consumed_q + 34'd1;
        if (bio_next < offset_width_q) begin
          offset_acc_d     = acc_next;
          byte_in_offset_d = bio_next[1:0];
        end else begin
          emit               = 1'b1;
          res_o.kind         = cffip_pkg::KindOffset;
          res_o.value        = offset_val;
          res_o.entry_number = entries_done_q[15:0];
          byte_in_offset_d   = '0;
          offset_acc_d       = '0;
          entries_done_d     = entries_done_q + 17'd1;
          if (entries_done_q == {1'b0, entry_count_q}) begin
            data_remaining_d = offset_val;
            if (offset_val == 32'd0) begin
              res_o.is_last = 1'b1;
              phase_d       = PhCountHi;
            end else begin
              phase_d = PhData;
            end
          end
        end
      end
      PhData: begin
        bytes_consumed_d = bytes_consumed_q + 34'd1;
        emit             = 1'b1;
        res_o.kind       = cffip_pkg::KindData;
        res_o.value      = {24'd0, stream_byte_i};
        data_remaining_d = dr_next;
        if (dr_next == 32'd0) begin
          res_o.is_last = 1'b1;
          phase_d       = PhCountHi;
        end
      end
      default: begin
        bytes_consumed_d = 34'd1;
        entry_count_d    = {8'd0, stream_byte_i};
        phase_d          = PhCountLo;
      end
    endcase

    res_o.index_bytes = res_o.is_last ? bytes_consumed_d[32:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= PhCountHi;
      entry_count_q    <= '0;
      offset_width_q   <= '0;
      entries_done_q   <= '0;
      byte_in_offset_q <= '0;
      offset_acc_q     <= '0;
      data_remaining_q <= '0;
      bytes_consumed_q <= '0;
    end else if (accept) begin
      phase_q          <= phase_d;
      entry_count_q    <= entry_count_d;
      offset_width_q   <= offset_width_d;
      entries_done_q   <= entries_done_d;
      byte_in_offset_q <= byte_in_offset_d;
      offset_acc_q     <= offset_acc_d;
      data_remaining_q <= data_remaining_d;
      bytes_consumed_q <= bytes_consumed_d;
    end
  end

endmodule

// ===== rtl/core/cffip_queue.sv =====
// Back end of the CFF INDEX parser: a small result queue that holds
// finished words and presents them to the output channel.
// Depends on cffip_pkg.
module cffip_queue #(
  parameter int unsigned Depth = cffip_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  cffip_pkg::result_t  push_word_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output cffip_pkg::result_t  pop_word_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cffip_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != FullCnt);
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_word_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/cff_index_parser_core.sv =====
// CFF INDEX parser top level: parser front end feeding a result queue.
// A result is written into the queue when the byte causing it is accepted.
// Throughput: one byte per cycle while the queue has room, set by the phase
// update per byte in the front end; input continues while a result waits.
// Reset (rst_ni, asynchronous, active low) returns the parser to idle,
// awaiting the count high byte, and empties the queue.
module cff_index_parser_core #(
  parameter int unsigned QueueDepth = cffip_pkg::QueueDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   stream_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   kind_o,
  output logic [cffip_pkg::ValueW-1:0] value_o,
  output logic [cffip_pkg::EntryW-1:0] entry_number_o,
  output logic                         is_last_o,
  output logic [cffip_pkg::TotalW-1:0] index_bytes_o
);

  cffip_pkg::result_t front_word;
  cffip_pkg::result_t out_word;
  logic               front_valid;
  logic               queue_ready;

  cffip_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .stream_byte_i (stream_byte_i),
    .res_valid_o   (front_valid),
    .res_ready_i   (queue_ready),
    .res_o         (front_word)
  );

  cffip_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (queue_ready),
    .push_word_i  (front_word),
    .pop_valid_o  (out_valid_o),
    .pop_ready_i  (out_ready_i),
    .pop_word_o   (out_word)
  );

  assign kind_o         = out_word.kind;
  assign value_o        = out_word.value;
  assign entry_number_o = out_word.entry_number;
  assign is_last_o      = out_word.is_last;
  assign index_bytes_o  = out_word.index_bytes;

  a_size_only_on_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_last_o |-> index_bytes_o == '0)
    else $error("total size shown on a word that is not the last");

  a_error_ends_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == cffip_pkg::KindEmpty || kind_o == cffip_pkg::KindBadSize)
      |-> is_last_o)
    else $error("empty or bad-size word does not end the index");

  a_entry_only_on_offset : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != cffip_pkg::KindOffset |-> entry_number_o == '0)
    else $error("entry number set on a word that is not an offset");

  a_no_drop_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o || $past(!front_valid))
    else $error("accepted result word did not reach the queue");

endmodule
